// File: rtl/pcf_pkg.sv
// Shared types and codes for the pixel color filter.
`timescale 1ns / 1ps

package pcf_pkg;

    // One pixel word on the input side.
    typedef struct packed {
        logic [7:0] alpha_in;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    // One pixel word on the output side.
    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pixel_out_t;

    // Filter modes; code 7 is unused and passes the pixel through.
    typedef enum logic [2:0] {
        MODE_INVERT     = 3'd0,
        MODE_GREY       = 3'd1,
        MODE_SEPIA      = 3'd2,
        MODE_POSTERIZE  = 3'd3,
        MODE_THRESHOLD  = 3'd4,
        MODE_BRIGHTNESS = 3'd5,
        MODE_CONTRAST   = 3'd6
    } filter_mode_t;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_FILTER_MODE   = 1'b0,
        REG_ADJUST_AMOUNT = 1'b1
    } reg_index_t;

endpackage

// File: rtl/pixel_color_filter_unit.sv
// Pixel color filter: point adjustment of one ARGB8888 pixel word per clock
// while the output is not stalled. A word passes the input reg, then the result reg.
// Throughput: one pixel word per clock unless a held result stalls the input;
// the mode mux between the two registers is one pass of multiplies and clamps.
// Reset: both stages empty, filter_mode 0 (invert), adjust_amount 0.
`timescale 1ns / 1ps

module pixel_color_filter_unit (
    input  logic              clk,
    input  logic              rst_n,

    // pixel input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  pcf_pkg::pixel_in_t  in_data,

    // pixel output channel
    output logic              out_valid,
    input  logic              out_stall,
    output pcf_pkg::pixel_out_t out_data,

    // APB-style register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Luma weights (x10000) and rounding/threshold points.
    localparam logic [21:0] LUMA_R      = 22'd2126;
    localparam logic [21:0] LUMA_G      = 22'd7152;
    localparam logic [21:0] LUMA_B      = 22'd722;
    localparam logic [21:0] LUMA_ROUND  = 22'd5000;
    localparam logic [21:0] LUMA_THRESH = 22'd1280000;   // 128 * 10000

    // floor(x / 10000) == (x * 1717987) >> 34 for x below 2^22
    localparam logic [42:0] RECIP_10000 = 43'd1717987;
    // floor(x / 1000)  == (x * 268436) >> 28 for x below 490000
    localparam logic [37:0] RECIP_1000  = 38'd268436;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]        mode_reg,   mode_next;
    logic signed [8:0] amount_reg, amount_next;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        mode_next   = mode_reg;
        amount_next = amount_reg;
        if (cfg_write)
        begin
            unique case (pcf_pkg::reg_index_t'(paddr[2]))
                pcf_pkg::REG_FILTER_MODE:   mode_next   = pwdata[2:0];
                pcf_pkg::REG_ADJUST_AMOUNT: amount_next = $signed(pwdata[8:0]);
            endcase
        end
    end

    always_comb
    begin
        unique case (pcf_pkg::reg_index_t'(paddr[2]))
            pcf_pkg::REG_FILTER_MODE:   prdata = {29'd0, mode_reg};
            pcf_pkg::REG_ADJUST_AMOUNT: prdata = {{23{amount_reg[8]}}, amount_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= pcf_pkg::MODE_INVERT;
            amount_reg <= 9'sd0;
        end
        else
        begin
            mode_reg   <= mode_next;
            amount_reg <= amount_next;
        end
    end

    // ------------------------------------------------------------------
    // Two-stage pipeline handshake: input reg -> result reg.
    // Stage 1 moves on when the result reg is empty or being taken.
    // ------------------------------------------------------------------
    logic                 s1_valid_reg, s1_valid_next;
    pcf_pkg::pixel_in_t   s1_data_reg;
    logic                 out_valid_reg, out_valid_next;
    pcf_pkg::pixel_out_t  out_data_reg, out_data_next;
    logic                 out_take;
    logic                 s1_adv;
    logic                 in_acc;

    assign out_take = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_take;
    assign in_stall = s1_valid_reg && !out_take;
    assign in_acc   = in_valid && !in_stall;

    assign s1_valid_next  = in_acc || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel helpers
    // ------------------------------------------------------------------

    // Clamp a signed value to 0..255.
    function automatic logic [7:0] clamp8(input logic signed [17:0] v);
        logic [7:0] res;
        if (v < 18'sd0)
            res = 8'd0;
        else if (v > 18'sd255)
            res = 8'd255;
        else
            res = v[7:0];
        return res;
    endfunction

    // One sepia row: weighted sum / 1000, saturated at 255.
    function automatic logic [7:0] sepia_ch(
        input logic [7:0]  r,
        input logic [7:0]  g,
        input logic [7:0]  b,
        input logic [18:0] wr,
        input logic [18:0] wg,
        input logic [18:0] wb
    );
        logic [18:0] sum;
        logic [37:0] prod;
        logic [9:0]  quo;
        sum  = {11'd0, r} * wr + {11'd0, g} * wg + {11'd0, b} * wb;
        prod = {19'd0, sum} * RECIP_1000;
        quo  = prod[37:28];
        return (quo > 10'd255) ? 8'd255 : quo[7:0];
    endfunction

    // Brightness: channel plus signed offset, clamped.
    function automatic logic [7:0] bright_ch(
        input logic [7:0]        c,
        input logic signed [8:0] amt
    );
        logic signed [17:0] v;
        v = $signed({10'd0, c}) + 18'(amt);
        return clamp8(v);
    endfunction

    // Contrast: 128 + floor((c - 128) * fp / 128), clamped.
    function automatic logic [7:0] contrast_ch(
        input logic [7:0]        c,
        input logic signed [9:0] fp
    );
        logic signed [17:0] d;
        logic signed [17:0] p;
        logic signed [17:0] s;
        d = $signed({10'd0, c}) - 18'sd128;
        p = d * 18'(fp);
        s = (p >>> 7) + 18'sd128;
        return clamp8(s);
    endfunction

    // ------------------------------------------------------------------
    // Filter datapath on the input register
    // ------------------------------------------------------------------
    logic [7:0]        px_a, px_r, px_g, px_b;
    logic [21:0]       luma_sum;
    logic [21:0]       luma_rnd;
    logic [42:0]       grey_prod;
    logic [7:0]        grey_val;
    logic [7:0]        thresh_val;
    logic signed [9:0] contrast_fp;
    logic [7:0]        nr, ng, nb;

    assign px_a = s1_data_reg.alpha_in;
    assign px_r = s1_data_reg.red_in;
    assign px_g = s1_data_reg.green_in;
    assign px_b = s1_data_reg.blue_in;

    assign luma_sum   = {14'd0, px_r} * LUMA_R + {14'd0, px_g} * LUMA_G
                      + {14'd0, px_b} * LUMA_B;
    assign luma_rnd   = luma_sum + LUMA_ROUND;
    assign grey_prod  = {21'd0, luma_rnd} * RECIP_10000;
    assign grey_val   = grey_prod[41:34];
    // unrounded luma >= 128 is the same as the weighted sum >= 1280000
    assign thresh_val = (luma_sum >= LUMA_THRESH) ? 8'd255 : 8'd0;

    assign contrast_fp = 10'sd128 + 10'(amount_reg);

    always_comb
    begin
        nr = px_r;
        ng = px_g;
        nb = px_b;
        case (mode_reg)
            pcf_pkg::MODE_INVERT:
            begin
                nr = ~px_r;
                ng = ~px_g;
                nb = ~px_b;
            end
            pcf_pkg::MODE_GREY:
            begin
                nr = grey_val;
                ng = grey_val;
                nb = grey_val;
            end
            pcf_pkg::MODE_SEPIA:
            begin
                nr = sepia_ch(px_r, px_g, px_b, 19'd393, 19'd769, 19'd189);
                ng = sepia_ch(px_r, px_g, px_b, 19'd349, 19'd686, 19'd168);
                nb = sepia_ch(px_r, px_g, px_b, 19'd272, 19'd534, 19'd131);
            end
            pcf_pkg::MODE_POSTERIZE:
            begin
                // (c / 64) * 85: top two bits repeated fill 0, 85, 170, 255
                nr = {4{px_r[7:6]}};
                ng = {4{px_g[7:6]}};
                nb = {4{px_b[7:6]}};
            end
            pcf_pkg::MODE_THRESHOLD:
            begin
                nr = thresh_val;
                ng = thresh_val;
                nb = thresh_val;
            end
            pcf_pkg::MODE_BRIGHTNESS:
            begin
                // fully transparent pixels are left alone
                if (px_a != 8'd0)
                begin
                    nr = bright_ch(px_r, amount_reg);
                    ng = bright_ch(px_g, amount_reg);
                    nb = bright_ch(px_b, amount_reg);
                end
            end
            pcf_pkg::MODE_CONTRAST:
            begin
                nr = contrast_ch(px_r, contrast_fp);
                ng = contrast_ch(px_g, contrast_fp);
                nb = contrast_ch(px_b, contrast_fp);
            end
            default:
            begin
                // unused mode code: pass through
                nr = px_r;
                ng = px_g;
                nb = px_b;
            end
        endcase
    end

    assign out_data_next.alpha_out = px_a;
    assign out_data_next.red_out   = nr;
    assign out_data_next.green_out = ng;
    assign out_data_next.blue_out  = nb;

`ifndef SYNTHESIS
    // input side only backs up when stage 1 holds a word
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall with empty input stage");

    // a stage-1 word moving on lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced word lost");

    // alpha always rides through unchanged
    a_alpha_through: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (out_data_reg.alpha_out == $past(s1_data_reg.alpha_in)))
        else $error("alpha altered");

    // a stalled result is never dropped
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");
`endif

endmodule

// File: sim/pixel_color_filter_unit_tb.sv
// Self-checking testbench for the pixel color filter unit.
`timescale 1ns / 1ps

module pixel_color_filter_unit_tb;

    // mode code 7 has no filter behind it: pixel passes through unchanged
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int SEGMENTS_PER_PHASE  = 8;
    localparam int WORDS_PER_SEGMENT   = 30;
    localparam int HOLD_OFF_CYCLES     = 150;
    localparam int DRAIN_LIMIT_CYCLES  = 10000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    pcf_pkg::pixel_in_t  in_data;
    logic                out_valid;
    logic                out_stall;
    pcf_pkg::pixel_out_t out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // shadow copy of the filter registers, updated when a write lands
    logic [2:0]        mode_q;
    logic signed [8:0] amount_q;

    pcf_pkg::pixel_out_t expected_pixels[$];
    int                  fail_count;
    int                  readback_errors;
    int                  tx_idle_pct;
    int                  rx_stall_pct;
    // long hold-off: tests bump hold_requests, the stall process counts it out
    int                  hold_requests;
    int                  hold_served;
    int                  hold_left;

    pixel_color_filter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: a hung run ends with FAIL.
    initial
    begin
        #2_000_000;
        $display("pixel_color_filter_unit_tb: FAIL");
        $finish;
    end

    //--------------------------------------------------------------------
    // Pixel math
    //--------------------------------------------------------------------

    function automatic logic [7:0] clamp8(int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // 128 + floor((c - 128) * gain / 128); >>> on a signed int floors
    function automatic logic [7:0] contrast_channel(int c, int gain);
        return clamp8(128 + (((c - 128) * gain) >>> 7));
    endfunction

    function automatic pcf_pkg::pixel_out_t filter_pixel(pcf_pkg::pixel_in_t px);
        pcf_pkg::pixel_out_t res;
        int r;
        int g;
        int b;
        int amt;
        int luma;
        r   = px.red_in;
        g   = px.green_in;
        b   = px.blue_in;
        amt = amount_q;
        res.alpha_out = px.alpha_in;
        res.red_out   = px.red_in;
        res.green_out = px.green_in;
        res.blue_out  = px.blue_in;
        case (mode_q)
            pcf_pkg::MODE_INVERT:
            begin
                res.red_out   = 8'd255 - px.red_in;
                res.green_out = 8'd255 - px.green_in;
                res.blue_out  = 8'd255 - px.blue_in;
            end
            pcf_pkg::MODE_GREY:
            begin
                luma = (2126 * r + 7152 * g + 722 * b + 5000) / 10000;
                res.red_out   = clamp8(luma);
                res.green_out = clamp8(luma);
                res.blue_out  = clamp8(luma);
            end
            pcf_pkg::MODE_SEPIA:
            begin
                res.red_out   = clamp8((393 * r + 769 * g + 189 * b) / 1000);
                res.green_out = clamp8((349 * r + 686 * g + 168 * b) / 1000);
                res.blue_out  = clamp8((272 * r + 534 * g + 131 * b) / 1000);
            end
            pcf_pkg::MODE_POSTERIZE:
            begin
                res.red_out   = clamp8((r / 64) * 85);
                res.green_out = clamp8((g / 64) * 85);
                res.blue_out  = clamp8((b / 64) * 85);
            end
            pcf_pkg::MODE_THRESHOLD:
            begin
                // luma truncated, no rounding term here
                luma = (2126 * r + 7152 * g + 722 * b) / 10000;
                res.red_out   = (luma >= 128) ? 8'd255 : 8'd0;
                res.green_out = res.red_out;
                res.blue_out  = res.red_out;
            end
            pcf_pkg::MODE_BRIGHTNESS:
            begin
                // fully transparent pixels are left alone
                if (px.alpha_in != 8'd0)
                begin
                    res.red_out   = clamp8(r + amt);
                    res.green_out = clamp8(g + amt);
                    res.blue_out  = clamp8(b + amt);
                end
            end
            pcf_pkg::MODE_CONTRAST:
            begin
                res.red_out   = contrast_channel(r, 128 + amt);
                res.green_out = contrast_channel(g, 128 + amt);
                res.blue_out  = contrast_channel(b, 128 + amt);
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    //--------------------------------------------------------------------
    // Random content
    //--------------------------------------------------------------------

    // bias toward the rails and the posterize/contrast break points
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:
            begin
                case ($urandom_range(3))
                    0:       return 8'd63;
                    1:       return 8'd64;
                    2:       return 8'd127;
                    default: return 8'd128;
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pcf_pkg::pixel_in_t rand_pixel();
        pcf_pkg::pixel_in_t px;
        case ($urandom_range(7))
            0:       px.alpha_in = 8'd0;
            1:       px.alpha_in = 8'd255;
            default: px.alpha_in = 8'($urandom);
        endcase
        px.red_in   = rand_channel();
        px.green_in = rand_channel();
        px.blue_in  = rand_channel();
        return px;
    endfunction

    function automatic int rand_amount();
        case ($urandom_range(5))
            0:       return -256;
            1:       return 255;
            2:       return -255;
            3:       return 0;
            default: return int'($urandom_range(511)) - 256;
        endcase
    endfunction

    //--------------------------------------------------------------------
    // Bus tasks
    //--------------------------------------------------------------------

    // APB write: setup then access; register lands at the access edge.
    // The bus then goes idle and the register is read back.
    task automatic write_reg(pcf_pkg::reg_index_t idx, logic [31:0] value);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == pcf_pkg::REG_FILTER_MODE)
            mode_q = value[2:0];
        else
            amount_q = value[8:0];
        @(posedge clk);
        // paddr still points at the register just written
        if (idx == pcf_pkg::REG_FILTER_MODE)
            want = 32'(mode_q);
        else
            want = 32'(amount_q);
        if (prdata !== want)
        begin
            $error("prdata: expected %0h, got %0h", want, prdata);
            readback_errors++;
        end
    endtask

    // Offer one pixel word; valid stays high afterwards until the next
    // idle slot or release_input, so back-to-back words need no gap.
    task automatic send_pixel(pcf_pkg::pixel_in_t px);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Every word yields a result, so an empty queue means the pipe is idle;
    // the wait that follows is a margin on top of that.
    task automatic wait_drained();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_filter(logic [2:0] mode, int amount);
        write_reg(pcf_pkg::REG_FILTER_MODE, 32'(mode));
        write_reg(pcf_pkg::REG_ADJUST_AMOUNT, 32'(amount));
    endtask

    //--------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------

    // Black and transparent white through every mode, unused code included.
    task automatic test_mode_extremes();
        for (int m = 0; m <= int'(MODE_UNUSED); m++)
        begin
            set_filter(m[2:0], 100);
            send_pixel({8'hFF, 8'h00, 8'h00, 8'h00});
            send_pixel({8'h00, 8'hFF, 8'hFF, 8'hFF});
            release_input();
            wait_drained();
        end
    endtask

    // Full signed range of adjust_amount, and the threshold boundary.
    task automatic test_adjust_extremes();
        set_filter(pcf_pkg::MODE_BRIGHTNESS, 255);
        send_pixel({8'h01, 8'h00, 8'h80, 8'hFF});
        release_input();
        wait_drained();
        set_filter(pcf_pkg::MODE_BRIGHTNESS, -256);
        send_pixel({8'hFF, 8'h00, 8'h80, 8'hFF});
        release_input();
        wait_drained();
        set_filter(pcf_pkg::MODE_CONTRAST, -256);
        send_pixel({8'hFF, 8'h00, 8'h80, 8'hFF});
        release_input();
        wait_drained();
        set_filter(pcf_pkg::MODE_CONTRAST, 255);
        send_pixel({8'hFF, 8'h00, 8'h7F, 8'hFF});
        release_input();
        wait_drained();
        // luma exactly 128 goes white, one step below goes black
        set_filter(pcf_pkg::MODE_THRESHOLD, 0);
        send_pixel({8'h80, 8'h80, 8'h80, 8'h80});
        send_pixel({8'h80, 8'h7F, 8'h80, 8'h80});
        release_input();
        wait_drained();
    endtask

    // Segments of random pixels, each under a fresh random setting.
    task automatic test_random_stream(int tx_idle, int rx_stall);
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        for (int s = 0; s < SEGMENTS_PER_PHASE; s++)
        begin
            set_filter(3'($urandom_range(7)), rand_amount());
            for (int i = 0; i < WORDS_PER_SEGMENT; i++)
                send_pixel(rand_pixel());
            release_input();
            wait_drained();
        end
    endtask

    // Receiver holds off while the sender keeps pushing: the pipe fills and
    // in_stall has to rise. Then a full drain, and a contrast run under random stall.
    task automatic test_output_hold();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        set_filter(pcf_pkg::MODE_SEPIA, 0);
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_pixel(rand_pixel());
        release_input();
        wait_drained();
        rx_stall_pct = 30;
        set_filter(pcf_pkg::MODE_CONTRAST, rand_amount());
        for (int i = 0; i < 20; i++)
            send_pixel(rand_pixel());
        release_input();
        wait_drained();
    endtask

    //--------------------------------------------------------------------
    // Receiver stall generator; a pending hold-off wins over random stall
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_OFF_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    //--------------------------------------------------------------------
    // Scoreboard: predict on input accept, compare on output accept.
    // Push comes first so a combinational pass-through pipe would still line up.
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        pcf_pkg::pixel_out_t want;
        if (rst_n && in_valid && !in_stall)
            expected_pixels.push_back(filter_pixel(in_data));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result word %h with nothing expected", out_data);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (out_data.alpha_out !== want.alpha_out)
                begin
                    $error("alpha_out: expected %0d, got %0d",
                           want.alpha_out, out_data.alpha_out);
                    fail_count++;
                end
                if (out_data.red_out !== want.red_out)
                begin
                    $error("red_out: expected %0d, got %0d",
                           want.red_out, out_data.red_out);
                    fail_count++;
                end
                if (out_data.green_out !== want.green_out)
                begin
                    $error("green_out: expected %0d, got %0d",
                           want.green_out, out_data.green_out);
                    fail_count++;
                end
                if (out_data.blue_out !== want.blue_out)
                begin
                    $error("blue_out: expected %0d, got %0d",
                           want.blue_out, out_data.blue_out);
                    fail_count++;
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------
    initial
    begin
        int drain_cycles;
        readback_errors = 0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        hold_requests   = 0;
        mode_q          = pcf_pkg::MODE_INVERT;
        amount_q        = '0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_mode_extremes();
        test_adjust_extremes();
        test_random_stream(16, 49);
        test_random_stream(49, 16);
        test_random_stream(0, 0);
        test_output_hold();

        drain_cycles = 0;
        while (expected_pixels.size() != 0 && drain_cycles < DRAIN_LIMIT_CYCLES)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (10) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $error("%0d expected result words never arrived",
                   expected_pixels.size());
            readback_errors++;
        end

        if (fail_count == 0 && readback_errors == 0)
            $display("pixel_color_filter_unit_tb: PASS");
        else
            $display("pixel_color_filter_unit_tb: FAIL");
        $finish;
    end

endmodule
